// ----- hw/rtl/rc4_stream_cipher_assert.svh -----
// Assertion macros shared by the RC4 cipher modules.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define RC4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rc4_pkg.sv -----
// Package for the RC4 stream cipher: widths, defaults, datapath commands and status.
// No dependencies; used by the interfaces, controller, datapath and top level.
`default_nettype none

package rc4_pkg;

  localparam int unsigned ByteW         = 8;
  localparam int unsigned KeyHalfW      = 64;
  localparam int unsigned KeyLenW       = 5;
  localparam int unsigned MaxKeyBytesDef = 16;
  localparam int unsigned PermDepth     = 256;
  localparam int unsigned PermAddrW     = 8;

  // One command per cycle from the controller to the datapath.
  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_CAPTURE = 4'd1,
    OP_INIT_WR = 4'd2,
    OP_KS_RD_I = 4'd3,
    OP_KS_RD_J = 4'd4,
    OP_KS_WR_I = 4'd5,
    OP_KS_WR_J = 4'd6,
    OP_G_RD_I  = 4'd7,
    OP_G_RD_J  = 4'd8,
    OP_G_WR_I  = 4'd9,
    OP_G_WR_J  = 4'd10
  } dp_op_e;

  typedef struct packed {
    logic last_n;    // sweep counter is at the final entry
    logic out_free;  // output register can take a new result this cycle
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rc4_if.sv -----
// Valid/ready channel interfaces for the RC4 cipher input and output transactions.
// Depends on rc4_pkg for field widths.
`default_nettype none

interface rc4_in_if;
  logic                             valid;
  logic                             ready;
  logic [rc4_pkg::ByteW-1:0]        data_in;
  logic                             start_of_message;
  logic [rc4_pkg::KeyHalfW-1:0]     key_low;
  logic [rc4_pkg::KeyHalfW-1:0]     key_high;
  logic [rc4_pkg::KeyLenW-1:0]      key_length;

  modport source (output valid, data_in, start_of_message, key_low, key_high, key_length,
                  input ready);
  modport sink   (input valid, data_in, start_of_message, key_low, key_high, key_length,
                  output ready);
endinterface

interface rc4_out_if;
  logic                      valid;
  logic                      ready;
  logic [rc4_pkg::ByteW-1:0] data_out;

  modport source (output valid, data_out, input ready);
  modport sink   (input valid, data_out, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rc4_stream_cipher.sv -----
// Top level of the RC4 stream cipher: joins the controller and the datapath.
// Depends on rc4_pkg, rc4_if (channel interfaces), rc4_ctrl and rc4_dp.
`default_nettype none

// RC4 cipher, one byte per input transaction: the output byte is the input byte XORed with the
// next keystream byte, so the same block encrypts and decrypts. A transaction with
// start_of_message set first runs the full key schedule with its key (key_length 1 to
// MAX_KEY_BYTES bytes; zero acts as one and larger values are clamped), then produces its byte.
// The 256-byte permutation lives in a memory with one write port and one registered read port,
// and that port pair sets the pace: after acceptance, a plain byte reads S[i], reads S[j], writes
// S[i] while reading the keystream entry and writes S[j] while loading the result before the
// block is ready again. A message start first adds the key schedule: writing the identity into
// all 256 entries, then 256 swap steps of two reads and two writes each. The result sits in an
// output register; if it has not been taken when the next result is due, the block waits.
// Before the first key schedule the permutation holds no defined contents, so the first
// transaction after reset must start a message.
module rc4_stream_cipher #(
  parameter int unsigned MAX_KEY_BYTES = rc4_pkg::MaxKeyBytesDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  rc4_in_if.sink     in_i,
  rc4_out_if.source  out_o
);

  rc4_pkg::dp_op_e     op;
  rc4_pkg::dp_status_t status;
  logic                in_ready;

  // The controller owns the state machine and the input handshake.
  rc4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_sop_i   (in_i.start_of_message),
    .in_ready_o (in_ready),
    .status_i   (status),
    .op_o       (op)
  );

  assign in_i.ready = in_ready;

  // The datapath holds the permutation, the indices, the key and the result register.
  rc4_dp #(
    .MaxKeyBytes (MAX_KEY_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .data_in_i    (in_i.data_in),
    .sop_i        (in_i.start_of_message),
    .key_low_i    (in_i.key_low),
    .key_high_i   (in_i.key_high),
    .key_length_i (in_i.key_length),
    .status_o     (status),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .data_out_o   (out_o.data_out)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/rc4_ctrl.sv -----
// Controller of the RC4 cipher: sequences key schedule and generator steps.
// Depends on rc4_pkg for the command and status types.
`default_nettype none

module rc4_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  in_sop_i,
  output logic                 in_ready_o,
  input  rc4_pkg::dp_status_t  status_i,
  output rc4_pkg::dp_op_e      op_o
);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_KS_INIT = 10'b00_0000_0010,
    ST_KS_RD_I = 10'b00_0000_0100,
    ST_KS_RD_J = 10'b00_0000_1000,
    ST_KS_WR_I = 10'b00_0001_0000,
    ST_KS_WR_J = 10'b00_0010_0000,
    ST_G_RD_I  = 10'b00_0100_0000,
    ST_G_RD_J  = 10'b00_1000_0000,
    ST_G_WR_I  = 10'b01_0000_0000,
    ST_G_WR_J  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    op_o    = rc4_pkg::OP_NOP;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_o    = rc4_pkg::OP_CAPTURE;
          state_d = in_sop_i ? ST_KS_INIT : ST_G_RD_I;
        end
      end
      ST_KS_INIT: begin
        op_o = rc4_pkg::OP_INIT_WR;
        if (status_i.last_n) begin
          state_d = ST_KS_RD_I;
        end
      end
      ST_KS_RD_I: begin
        op_o    = rc4_pkg::OP_KS_RD_I;
        state_d = ST_KS_RD_J;
      end
      ST_KS_RD_J: begin
        op_o    = rc4_pkg::OP_KS_RD_J;
        state_d = ST_KS_WR_I;
      end
      ST_KS_WR_I: begin
        op_o    = rc4_pkg::OP_KS_WR_I;
        state_d = ST_KS_WR_J;
      end
      ST_KS_WR_J: begin
        op_o    = rc4_pkg::OP_KS_WR_J;
        state_d = status_i.last_n ? ST_G_RD_I : ST_KS_RD_I;
      end
      ST_G_RD_I: begin
        op_o    = rc4_pkg::OP_G_RD_I;
        state_d = ST_G_RD_J;
      end
      ST_G_RD_J: begin
        op_o    = rc4_pkg::OP_G_RD_J;
        state_d = ST_G_WR_I;
      end
      ST_G_WR_I: begin
        op_o    = rc4_pkg::OP_G_WR_I;
        state_d = ST_G_WR_J;
      end
      ST_G_WR_J: begin
        // The final swap write is repeated while the output register is full.
        op_o = rc4_pkg::OP_G_WR_J;
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`include "rc4_stream_cipher_assert.svh"

  `RC4_ASSERT_NEXT(a_sop_starts_ks, accept && in_sop_i, state_q == ST_KS_INIT, "sop did not start key schedule")
  `RC4_ASSERT_NEXT(a_ks_ends_in_gen, state_q == ST_KS_WR_J && status_i.last_n, state_q == ST_G_RD_I, "key schedule did not hand over to generator")
  `RC4_ASSERT_NEXT(a_stall_holds, state_q == ST_G_WR_J && !status_i.out_free, state_q == ST_G_WR_J, "result step left while output full")

endmodule

`default_nettype wire

// ----- hw/rtl/rc4_dp.sv -----
// Datapath of the RC4 cipher: permutation memory, indices, key store and output register.
// Depends on rc4_pkg; driven by rc4_ctrl through one command per cycle.
`default_nettype none

module rc4_dp #(
  parameter int unsigned MaxKeyBytes = rc4_pkg::MaxKeyBytesDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  rc4_pkg::dp_op_e                    op_i,
  input  wire [rc4_pkg::ByteW-1:0]           data_in_i,
  input  wire                                sop_i,
  input  wire [rc4_pkg::KeyHalfW-1:0]        key_low_i,
  input  wire [rc4_pkg::KeyHalfW-1:0]        key_high_i,
  input  wire [rc4_pkg::KeyLenW-1:0]         key_length_i,
  output rc4_pkg::dp_status_t                status_o,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [rc4_pkg::ByteW-1:0]          data_out_o
);

  localparam int unsigned KeyIdxW = (MaxKeyBytes > 1) ? $clog2(MaxKeyBytes) : 1;
  localparam int unsigned AW      = rc4_pkg::PermAddrW;
  localparam int unsigned BW      = rc4_pkg::ByteW;
  localparam int unsigned LW      = rc4_pkg::KeyLenW;

  logic [BW-1:0] perm_mem [rc4_pkg::PermDepth];

  logic [AW-1:0]      i_q, i_d, j_q, j_d, n_q, n_d;
  logic [KeyIdxW-1:0] k_q, k_d;
  logic [LW-1:0]      klen_q, klen_d;
  logic [BW-1:0]      key_q [MaxKeyBytes];
  logic [BW-1:0]      data_q, si_q, sj_q, rd_q, out_q, ks;
  logic               fwd_i_q, fwd_j_q, out_valid_q, out_valid_d;
  logic               wr_en, rd_en, out_load;
  logic [AW-1:0]      wa, ra, ks_sum, gen_j, t_addr;
  logic [BW-1:0]      wd;
  logic [2*rc4_pkg::KeyHalfW-1:0] key_all;

  assign key_all = {key_high_i, key_low_i};
  assign ks_sum  = j_q + rd_q + key_q[k_q];
  assign gen_j   = j_q + rd_q;
  assign t_addr  = si_q + rd_q;

  assign status_o.last_n   = (n_q == AW'(rc4_pkg::PermDepth - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Later write wins: S[j] was written after S[i].
  assign ks       = fwd_j_q ? si_q : (fwd_i_q ? sj_q : rd_q);
  assign out_load = (op_i == rc4_pkg::OP_G_WR_J) && status_o.out_free;

  always_comb begin
    wr_en = 1'b0;
    wa    = n_q;
    wd    = rd_q;
    rd_en = 1'b0;
    ra    = n_q;
    case (op_i)
      rc4_pkg::OP_INIT_WR: begin
        wr_en = 1'b1;
        wd    = n_q;
      end
      rc4_pkg::OP_KS_RD_I: begin
        rd_en = 1'b1;
      end
      rc4_pkg::OP_KS_RD_J: begin
        rd_en = 1'b1;
        ra    = ks_sum;
      end
      rc4_pkg::OP_KS_WR_I: begin
        wr_en = 1'b1;
      end
      rc4_pkg::OP_KS_WR_J: begin
        wr_en = 1'b1;
        wa    = j_q;
        wd    = si_q;
      end
      rc4_pkg::OP_G_RD_I: begin
        rd_en = 1'b1;
        ra    = i_q + AW'(1);
      end
      rc4_pkg::OP_G_RD_J: begin
        rd_en = 1'b1;
        ra    = gen_j;
      end
      rc4_pkg::OP_G_WR_I: begin
        wr_en = 1'b1;
        wa    = i_q;
        rd_en = 1'b1;
        ra    = t_addr;
      end
      rc4_pkg::OP_G_WR_J: begin
        wr_en = 1'b1;
        wa    = j_q;
        wd    = si_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    i_d    = i_q;
    j_d    = j_q;
    n_d    = n_q;
    k_d    = k_q;
    klen_d = klen_q;
    case (op_i)
      rc4_pkg::OP_CAPTURE: begin
        if (sop_i) begin
          n_d = '0;
          k_d = '0;
          j_d = '0;
          if (key_length_i == '0) begin
            klen_d = LW'(1);
          end else if (key_length_i > LW'(MaxKeyBytes)) begin
            klen_d = LW'(MaxKeyBytes);
          end else begin
            klen_d = key_length_i;
          end
        end
      end
      rc4_pkg::OP_INIT_WR: begin
        n_d = n_q + AW'(1);
      end
      rc4_pkg::OP_KS_RD_J: begin
        j_d = ks_sum;
      end
      rc4_pkg::OP_KS_WR_J: begin
        n_d = n_q + AW'(1);
        if ((LW'(k_q) + LW'(1)) >= klen_q) begin
          k_d = '0;
        end else begin
          k_d = k_q + KeyIdxW'(1);
        end
        if (status_o.last_n) begin
          i_d = '0;
          j_d = '0;
        end
      end
      rc4_pkg::OP_G_RD_I: begin
        i_d = i_q + AW'(1);
      end
      rc4_pkg::OP_G_RD_J: begin
        j_d = gen_j;
      end
      default: begin
        i_d = i_q;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      k_q         <= '0;
      klen_q      <= LW'(1);
      out_valid_q <= 1'b0;
    end else begin
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      k_q         <= k_d;
      klen_q      <= klen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == rc4_pkg::OP_CAPTURE) begin
      data_q <= data_in_i;
      if (sop_i) begin
        for (int b = 0; b < MaxKeyBytes; b++) begin
          key_q[b] <= key_all[8*b +: 8];
        end
      end
    end
    if (op_i == rc4_pkg::OP_KS_RD_J || op_i == rc4_pkg::OP_G_RD_J) begin
      si_q <= rd_q;
    end
    if (op_i == rc4_pkg::OP_G_WR_I) begin
      sj_q    <= rd_q;
      fwd_i_q <= (t_addr == i_q);
      fwd_j_q <= (t_addr == j_q);
    end
    if (out_load) begin
      out_q <= data_q ^ ks;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      perm_mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_q <= perm_mem[ra];
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_q;

`include "rc4_stream_cipher_assert.svh"

  `RC4_ASSERT_NEXT(a_load_sets_valid, out_load, out_valid_q, "result load did not raise valid")
  `RC4_ASSERT_NEXT(a_ks_end_clears_idx, op_i == rc4_pkg::OP_KS_WR_J && status_o.last_n, i_q == '0 && j_q == '0, "indices not cleared after key schedule")

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the RC4 stream cipher: drives byte transactions, predicts each
// output byte with its own RC4 state and compares. Depends on rc4_pkg, rc4_if and the RTL top.

module tb;

  // The block is built with its default key size, so the clamp of key_length follows it.
  localparam int unsigned MaxKeyBytes = rc4_pkg::MaxKeyBytesDef;
  localparam int unsigned RandomBytes = 1230;
  // Once this many bytes have been checked, the receiver holds off for a long stretch. The hold
  // outlasts a whole key schedule, so the block backs up whatever it happens to be doing.
  localparam int unsigned HoldAfter   = 300;
  localparam int unsigned HoldCycles  = 2000;
  // The margin covers a plain byte and also the longest receiver idle, so a stray extra
  // transaction at the end is still seen.
  localparam int unsigned DrainCycles = 100;

  typedef struct packed {
    logic [rc4_pkg::ByteW-1:0]    data;
    logic                         som;
    logic [rc4_pkg::KeyHalfW-1:0] key_low;
    logic [rc4_pkg::KeyHalfW-1:0] key_high;
    logic [rc4_pkg::KeyLenW-1:0]  key_length;
  } cipher_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rc4_in_if  req_if ();
  rc4_out_if rsp_if ();

  rc4_stream_cipher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if.sink),
    .out_o  (rsp_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Transactions waiting to be offered, and the output bytes predicted but not yet seen.
  cipher_req_t               pending_reqs[$];
  logic [rc4_pkg::ByteW-1:0] expected_bytes[$];

  // Private copy of the cipher state, advanced once per accepted input transaction.
  logic [rc4_pkg::ByteW-1:0] sbox[rc4_pkg::PermDepth];
  logic [rc4_pkg::ByteW-1:0] pos_i;
  logic [rc4_pkg::ByteW-1:0] pos_j;

  int unsigned mismatches    = 0;
  int unsigned bytes_checked = 0;

  // Runs the key schedule when the transaction starts a message, then one generator step,
  // and returns the data byte XORed with the keystream byte.
  function automatic logic [rc4_pkg::ByteW-1:0] cipher_byte(input cipher_req_t req);
    int unsigned                    klen;
    int unsigned                    k;
    int unsigned                    n;
    logic [rc4_pkg::ByteW-1:0]      j;
    logic [rc4_pkg::ByteW-1:0]      t;
    logic [rc4_pkg::ByteW-1:0]      si;
    logic [rc4_pkg::ByteW-1:0]      sj;
    logic [rc4_pkg::ByteW-1:0]      ks_idx;
    logic [2*rc4_pkg::KeyHalfW-1:0] key;
    if (req.som) begin
      // A length of zero behaves as one, and anything above the key size is clamped.
      klen = req.key_length;
      if (klen < 1) klen = 1;
      if (klen > MaxKeyBytes) klen = MaxKeyBytes;
      key = {req.key_high, req.key_low};
      for (n = 0; n < rc4_pkg::PermDepth; n++) sbox[n] = rc4_pkg::ByteW'(n);
      j = '0;
      k = 0;
      for (n = 0; n < rc4_pkg::PermDepth; n++) begin
        j = j + sbox[n] + key[8*k +: 8];
        t = sbox[n];
        sbox[n] = sbox[j];
        sbox[j] = t;
        k++;
        if (k >= klen) k = 0;
      end
      pos_i = '0;
      pos_j = '0;
    end
    pos_i = pos_i + 1'b1;
    si = sbox[pos_i];
    pos_j = pos_j + si;
    sj = sbox[pos_j];
    sbox[pos_i] = sj;
    sbox[pos_j] = si;
    ks_idx = si + sj;
    return req.data ^ sbox[ks_idx];
  endfunction

  function automatic void queue_req(input logic som, input logic [rc4_pkg::ByteW-1:0] data,
                                    input logic [rc4_pkg::KeyHalfW-1:0] lo,
                                    input logic [rc4_pkg::KeyHalfW-1:0] hi,
                                    input logic [rc4_pkg::KeyLenW-1:0] len);
    cipher_req_t req;
    req.data       = data;
    req.som        = som;
    req.key_low    = lo;
    req.key_high   = hi;
    req.key_length = len;
    pending_reqs.push_back(req);
  endfunction

  function automatic logic [rc4_pkg::KeyHalfW-1:0] rand_half();
    return {$urandom, $urandom};
  endfunction

  // Idle lengths: half are none, most of the rest are short and a few are long.
  // In a calm stretch there is no idling at all.
  function automatic int unsigned pick_idle(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] output transaction %0d: %s", $realtime, bytes_checked, what);
    mismatches++;
  endtask

  // Driver. An item stays offered until accepted; the prediction is taken from the payload
  // that was actually on the interface at the accepting edge.
  int unsigned src_idle;
  bit          calm_in;

  always @(posedge clk_i or negedge rst_ni) begin : drive_req
    cipher_req_t req;
    if (!rst_ni) begin
      req_if.valid            <= 1'b0;
      req_if.data_in          <= '0;
      req_if.start_of_message <= 1'b0;
      req_if.key_low          <= '0;
      req_if.key_high         <= '0;
      req_if.key_length       <= '0;
      src_idle                <= 0;
      calm_in                 <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        req.data       = req_if.data_in;
        req.som        = req_if.start_of_message;
        req.key_low    = req_if.key_low;
        req.key_high   = req_if.key_high;
        req.key_length = req_if.key_length;
        expected_bytes.push_back(cipher_byte(req));
      end
      if (!req_if.valid || req_if.ready) begin
        if (src_idle != 0) begin
          req_if.valid <= 1'b0;
          src_idle     <= src_idle - 1;
        end else if (pending_reqs.size() != 0) begin
          req = pending_reqs.pop_front();
          req_if.valid            <= 1'b1;
          req_if.data_in          <= req.data;
          req_if.start_of_message <= req.som;
          req_if.key_low          <= req.key_low;
          req_if.key_high         <= req.key_high;
          req_if.key_length       <= req.key_length;
          src_idle                <= pick_idle(calm_in);
          if ($urandom_range(0, 99) == 0) calm_in <= !calm_in;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Random idling after transactions and now and then while waiting, plus one long
  // hold-off during which the sender keeps offering, so the block backs up and stalls its input.
  int unsigned sink_idle;
  int unsigned hold_left;
  bit          hold_done;
  bit          calm_out;

  always @(posedge clk_i or negedge rst_ni) begin : drive_rsp_ready
    int unsigned gap;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      sink_idle    <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
      calm_out     <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) calm_out <= !calm_out;
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (!hold_done && bytes_checked >= HoldAfter) begin
        rsp_if.ready <= 1'b0;
        hold_left    <= HoldCycles - 1;
        hold_done    <= 1'b1;
      end else if (sink_idle != 0) begin
        rsp_if.ready <= 1'b0;
        sink_idle    <= sink_idle - 1;
      end else begin
        gap = 0;
        if ((rsp_if.valid && rsp_if.ready) || $urandom_range(0, 7) == 0) gap = pick_idle(calm_out);
        if (gap != 0) begin
          rsp_if.ready <= 1'b0;
          sink_idle    <= gap - 1;
        end else begin
          rsp_if.ready <= 1'b1;
        end
      end
    end
  end

  // Monitor: every accepted output transaction is matched against the oldest prediction.
  always @(posedge clk_i) begin : check_rsp
    logic [rc4_pkg::ByteW-1:0] want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", rsp_if.data_out));
      end else begin
        want = expected_bytes.pop_front();
        if (rsp_if.data_out !== want)
          report_mismatch($sformatf("data_out %02h, predicted %02h", rsp_if.data_out, want));
      end
      bytes_checked++;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int unsigned                 total;
    int unsigned                 msg_len;
    int unsigned                 b;
    int unsigned                 n_items;
    logic [rc4_pkg::KeyLenW-1:0] klen;

    rst_ni = 1'b0;

    // Directed part. The very first transaction must start a message, since the permutation
    // is undefined until a key schedule has run.
    queue_req(1'b1, 8'h00, '0, '0, 5'd1);                    // one-byte all-zero key
    queue_req(1'b0, 8'hff, rand_half(), rand_half(), 5'd31); // key fields ignored mid-message
    queue_req(1'b0, 8'h00, '0, '0, 5'd0);
    queue_req(1'b1, 8'hff, '1, '1, 5'd16);                   // longest key, all ones
    queue_req(1'b0, 8'h80, '0, '0, 5'd16);
    queue_req(1'b0, 8'h01, rand_half(), rand_half(), 5'd7);
    queue_req(1'b1, 8'h55, rand_half(), rand_half(), 5'd0);  // zero length acts as one
    queue_req(1'b0, 8'haa, rand_half(), rand_half(), 5'd0);
    queue_req(1'b1, 8'h3c, rand_half(), rand_half(), 5'd17); // just above the key size
    queue_req(1'b0, 8'hc3, '1, '1, 5'd31);
    queue_req(1'b1, 8'haa, '1, '1, 5'd31);                   // largest field value
    queue_req(1'b0, 8'h55, '0, '0, 5'd1);
    queue_req(1'b1, 8'h0f, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 5'd15);
    queue_req(1'b0, 8'hf0, rand_half(), rand_half(), 5'd3);
    queue_req(1'b0, 8'h7f, rand_half(), rand_half(), 5'd2);
    queue_req(1'b0, 8'hfe, '1, '1, 5'd0);
    queue_req(1'b1, 8'h12, rand_half(), rand_half(), 5'd8);  // low key half only
    queue_req(1'b0, 8'h34, '1, '1, 5'd0);
    queue_req(1'b1, 8'h56, rand_half(), rand_half(), 5'd9);  // first byte of the high half
    queue_req(1'b0, 8'h78, rand_half(), rand_half(), 5'd16);

    // Random part: whole messages with random keys and bytes. Most are short so that key
    // schedules recur often; a few run past 256 bytes so that index i wraps.
    total = 0;
    while (total < RandomBytes) begin
      msg_len = ($urandom_range(0, 99) < 5) ? $urandom_range(200, 300) : $urandom_range(1, 24);
      klen = ($urandom_range(0, 3) == 0) ? rc4_pkg::KeyLenW'($urandom_range(0, 31))
                                         : rc4_pkg::KeyLenW'($urandom_range(1, MaxKeyBytes));
      queue_req(1'b1, 8'($urandom), rand_half(), rand_half(), klen);
      for (b = 1; b < msg_len; b++)
        queue_req(1'b0, 8'($urandom), rand_half(), rand_half(), 5'($urandom));
      total += msg_len;
    end
    n_items = pending_reqs.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every transaction yields exactly one output transaction.
    while (bytes_checked < n_items) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (pending_reqs.size() != 0 || expected_bytes.size() != 0)
      report_mismatch("transactions left over at the end of the run");

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run, with every stall and idle at its longest.
  initial begin : watchdog
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
